@@ rtl/bpfa_pkg.sv @@
// Shared types and constants of the bitmap page frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package bpfa_pkg;

   localparam int REQ_W    = 2;
   localparam int FRAME_W  = 15;
   localparam int RUN_W    = 16;
   localparam int BC_W     = 16;
   localparam int STATUS_W = 2;

   localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_FREE    = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RESERVE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOMEM = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam int                  CSR_ADDR_W        = 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_BLOCK_COUNT = 2'd0;
   localparam logic [BC_W-1:0]     BLOCK_COUNT_RESET = 16'd32768;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_PREP,
      ST_DIVA,
      ST_DIVB,
      ST_RD,
      ST_WR,
      ST_SCAN,
      ST_GRANT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ rtl/bpfa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ rtl/bpfa_divc.sv @@
// Two-stage divider by a constant using an exact reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_divc #(
   parameter int XW      = 17,
   parameter int DIVISOR = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [XW-1:0] x,
   output logic               done,
   output logic      [XW-1:0] q,
   output logic      [XW-1:0] r
);

   localparam int L  = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
   localparam int SH = XW + L;
   localparam int RW = XW + 1;
   localparam int PW = XW + RW;
   localparam longint unsigned RECIP = ((longint'(1) << SH) + DIVISOR - 1) / DIVISOR;

   logic [PW-1:0] prod_ff;
   logic [XW-1:0] x1_ff;
   logic          v1_ff;
   logic [XW-1:0] q_est;
   logic [XW-1:0] qd;

   assign q_est = XW'(prod_ff >> SH);
   assign qd    = q_est * XW'(DIVISOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         done  <= 1'b0;
      end else begin
         v1_ff <= start;
         done  <= v1_ff;
      end
      prod_ff <= PW'(x) * PW'(RW'(RECIP));
      x1_ff   <= x;
      q       <= q_est;
      r       <= x1_ff - qd;
   end

endmodule

`default_nettype wire

@@ rtl/bitmap_page_frame_allocator.sv @@
// Top level of the first-fit bitmap page frame allocator.
//
// The frame bitmap lives in one RAM of MAX_FRAMES / WORD_BITS words, rounded up,
// a set bit meaning the frame is used. After reset an initial pass writes every
// word to all ones, one word per cycle, so the block takes no request until the
// pass is through; the block_count register can be written then. One request is
// worked on at a time, and the next request is taken while the previous result
// still waits in the output register. Frame numbers are split into word and bit
// by a constant divider. Free, reserve range and release range read and write
// back each map word touched, one after the other. Allocate streams one RAM read
// per cycle and stops at the first word that is not all ones; a scan of only
// full words fails, and an allocate with no full word to scan fails without
// reading the map. Rejected free and empty range requests skip the divider.
// The next request is taken in the cycle after the result is loaded.

`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_frame_allocator #(
   parameter int MAX_FRAMES = 32768,
   parameter int WORD_BITS  = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [bpfa_pkg::REQ_W-1:0]        req_type,
   input  wire logic [bpfa_pkg::FRAME_W-1:0]      req_frame,
   input  wire logic [bpfa_pkg::RUN_W-1:0]        req_run_length,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [bpfa_pkg::FRAME_W-1:0]      rsp_granted_frame,
   output logic      [bpfa_pkg::STATUS_W-1:0]     rsp_status,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [bpfa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                       pwdata,
   output logic      [31:0]                       prdata,
   output logic                                   pready
);

   import bpfa_pkg::*;

   localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int FULL_WORDS = MAX_FRAMES / WORD_BITS;
   localparam int AW         = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CNTW       = $clog2(MAP_WORDS + 1);
   localparam int BW         = $clog2(WORD_BITS);
   localparam int MFW        = $clog2(MAX_FRAMES + 1);
   localparam int CW         = (MFW > 17) ? MFW : 17;
   localparam int GW         = (AW + 7 > FRAME_W) ? AW + 7 : FRAME_W;
   localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

   state_type              state_ff, state_in;
   logic [AW-1:0]          init_addr_ff, init_addr_in;
   logic [REQ_W-1:0]       kind_ff, kind_in;
   logic [FRAME_W-1:0]     frame_ff, frame_in;
   logic [RUN_W-1:0]       run_ff, run_in;
   logic [CW-1:0]          last_ff, last_in;
   logic                   set_ff, set_in;
   logic [CNTW-1:0]        words_ff, words_in;
   logic [CNTW-1:0]        scan_addr_ff, scan_addr_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [AW-1:0]          chk_idx_ff, chk_idx_in;
   logic [AW-1:0]          qs_ff, qs_in;
   logic [BW-1:0]          rs_ff, rs_in;
   logic [AW-1:0]          qe_ff, qe_in;
   logic [BW-1:0]          re_ff, re_in;
   logic [AW-1:0]          w_ff, w_in;
   logic [AW-1:0]          found_idx_ff, found_idx_in;
   logic [BW-1:0]          found_bit_ff, found_bit_in;
   logic [FRAME_W-1:0]     res_frame_ff, res_frame_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [BC_W-1:0]        block_count_ff, block_count_in;

   logic                   div_start;
   logic [CW-1:0]          div_x;
   logic                   div_done;
   logic [CW-1:0]          div_q;
   logic [CW-1:0]          div_r;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [WORD_BITS-1:0]   mem_wdata;
   logic [AW-1:0]          mem_raddr;
   logic [WORD_BITS-1:0]   mem_rdata;

   logic [CW-1:0]          run_sum;
   logic [CW-1:0]          run_end;
   logic                   run_empty;
   logic                   free_ok;
   logic [CW-1:0]          q_clip;
   logic [BW-1:0]          lo_bit;
   logic [BW-1:0]          hi_bit;
   logic [WORD_BITS-1:0]   word_mask;
   logic [BW-1:0]          free_bit;
   logic [GW-1:0]          grant_full;
   logic                   rsp_load;

   bpfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   bpfa_divc #(
      .XW      (CW),
      .DIVISOR (WORD_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x     (div_x),
      .done  (div_done),
      .q     (div_q),
      .r     (div_r)
   );

   assign run_sum   = CW'(frame_ff) + CW'(run_ff);
   assign run_end   = (run_sum > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : run_sum;
   assign run_empty = (run_end <= CW'(frame_ff));
   assign free_ok   = (CW'(frame_ff) < CW'(block_count_ff)) &&
                      (CW'(frame_ff) < CW'(MAX_FRAMES));
   assign q_clip    = (div_q > CW'(FULL_WORDS)) ? CW'(FULL_WORDS) : div_q;
   assign grant_full = GW'(found_idx_ff) * GW'(WORD_BITS) + GW'(found_bit_ff);

   always_comb begin
      lo_bit = (w_ff == qs_ff) ? rs_ff : '0;
      hi_bit = (w_ff == qe_ff) ? re_ff : BW'(WORD_BITS - 1);
      for (int k = 0; k < WORD_BITS; k++) begin
         word_mask[k] = (BW'(k) >= lo_bit) && (BW'(k) <= hi_bit);
      end
   end

   always_comb begin
      free_bit = '0;
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
         if (!mem_rdata[k]) begin
            free_bit = BW'(k);
         end
      end
   end

   always_comb begin
      block_count_in = block_count_ff;
      if (psel && penable && pwrite && (paddr == ADDR_BLOCK_COUNT)) begin
         block_count_in = pwdata[BC_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_BLOCK_COUNT) ? {{(32-BC_W){1'b0}}, block_count_ff} : '0;

   always_comb begin
      state_in      = state_ff;
      init_addr_in  = init_addr_ff;
      kind_in       = kind_ff;
      frame_in      = frame_ff;
      run_in        = run_ff;
      last_in       = last_ff;
      set_in        = set_ff;
      words_in      = words_ff;
      scan_addr_in  = scan_addr_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      qs_in         = qs_ff;
      rs_in         = rs_ff;
      qe_in         = qe_ff;
      re_in         = re_ff;
      w_in          = w_ff;
      found_idx_in  = found_idx_ff;
      found_bit_in  = found_bit_ff;
      res_frame_in  = res_frame_ff;
      res_status_in = res_status_ff;
      div_start     = 1'b0;
      div_x         = CW'(frame_ff);
      mem_we        = 1'b0;
      mem_waddr     = w_ff;
      mem_wdata     = ONES;
      mem_raddr     = w_ff;
      rsp_load      = 1'b0;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            mem_we       = 1'b1;
            mem_waddr    = init_addr_ff;
            mem_wdata    = ONES;
            init_addr_in = init_addr_ff + AW'(1);
            if (init_addr_ff == AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in  = req_type;
               frame_in = req_frame;
               run_in   = req_run_length;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            res_frame_in  = '0;
            res_status_in = STATUS_OK;
            case (kind_ff)
               REQ_ALLOC: begin
                  div_start = 1'b1;
                  div_x     = CW'(block_count_ff);
                  state_in  = ST_DIVA;
               end
               REQ_FREE: begin
                  if (free_ok) begin
                     div_start = 1'b1;
                     last_in   = CW'(frame_ff);
                     set_in    = 1'b0;
                     state_in  = ST_DIVA;
                  end else begin
                     res_status_in = STATUS_RANGE;
                     state_in      = ST_DONE;
                  end
               end
               default: begin
                  if (run_empty) begin
                     state_in = ST_DONE;
                  end else begin
                     div_start = 1'b1;
                     last_in   = run_end - CW'(1);
                     set_in    = (kind_ff == REQ_RESERVE);
                     state_in  = ST_DIVA;
                  end
               end
            endcase
         end
         ST_DIVA: begin
            if (div_done) begin
               if (kind_ff == REQ_ALLOC) begin
                  words_in     = CNTW'(q_clip);
                  scan_addr_in = '0;
                  chk_vld_in   = 1'b0;
                  if (q_clip == '0) begin
                     res_status_in = STATUS_NOMEM;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  qs_in     = div_q[AW-1:0];
                  rs_in     = div_r[BW-1:0];
                  w_in      = div_q[AW-1:0];
                  div_start = 1'b1;
                  div_x     = last_ff;
                  state_in  = ST_DIVB;
               end
            end
         end
         ST_DIVB: begin
            if (div_done) begin
               qe_in    = div_q[AW-1:0];
               re_in    = div_r[BW-1:0];
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            mem_raddr = w_ff;
            state_in  = ST_WR;
         end
         ST_WR: begin
            mem_we    = 1'b1;
            mem_waddr = w_ff;
            mem_wdata = set_ff ? (mem_rdata | word_mask) : (mem_rdata & ~word_mask);
            if (w_ff == qe_ff) begin
               state_in = ST_DONE;
            end else begin
               w_in     = w_ff + AW'(1);
               state_in = ST_RD;
            end
         end
         ST_SCAN: begin
            mem_raddr = scan_addr_ff[AW-1:0];
            chk_idx_in = scan_addr_ff[AW-1:0];
            chk_vld_in = (scan_addr_ff < words_ff);
            if (scan_addr_ff < words_ff) begin
               scan_addr_in = scan_addr_ff + CNTW'(1);
            end
            if (chk_vld_ff && (mem_rdata != ONES)) begin
               mem_we       = 1'b1;
               mem_waddr    = chk_idx_ff;
               mem_wdata    = mem_rdata | (WORD_BITS'(1) << free_bit);
               found_idx_in = chk_idx_ff;
               found_bit_in = free_bit;
               chk_vld_in   = 1'b0;
               state_in     = ST_GRANT;
            end else if (chk_vld_ff && (CNTW'(chk_idx_ff) == words_ff - CNTW'(1))) begin
               res_status_in = STATUS_NOMEM;
               chk_vld_in    = 1'b0;
               state_in      = ST_DONE;
            end
         end
         ST_GRANT: begin
            res_frame_in  = grant_full[FRAME_W-1:0];
            res_status_in = STATUS_OK;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_frame_in  = res_frame_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         init_addr_ff   <= '0;
         chk_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         block_count_ff <= BLOCK_COUNT_RESET;
      end else begin
         state_ff       <= state_in;
         init_addr_ff   <= init_addr_in;
         chk_vld_ff     <= chk_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         block_count_ff <= block_count_in;
      end
      kind_ff       <= kind_in;
      frame_ff      <= frame_in;
      run_ff        <= run_in;
      last_ff       <= last_in;
      set_ff        <= set_in;
      words_ff      <= words_in;
      scan_addr_ff  <= scan_addr_in;
      chk_idx_ff    <= chk_idx_in;
      qs_ff         <= qs_in;
      rs_ff         <= rs_in;
      qe_ff         <= qe_in;
      re_ff         <= re_in;
      w_ff          <= w_in;
      found_idx_ff  <= found_idx_in;
      found_bit_ff  <= found_bit_in;
      res_frame_ff  <= res_frame_in;
      res_status_ff <= res_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_frame = rsp_frame_ff;
   assign rsp_status        = rsp_status_ff;

   // An allocation write sets exactly one bit that was clear.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && mem_we) |->
         ($countones(mem_wdata) == $countones(mem_rdata) + 1))
      else $error("allocation write does not set exactly one bit");

   // A reserve word never clears a used frame.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR && set_ff) |-> ((mem_wdata & mem_rdata) == mem_rdata))
      else $error("reserve cleared a used frame");

   // A failed request never reports a granted frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_granted_frame == '0))
      else $error("failed request carries a frame number");

   // A new result word only appears after a request reached the result state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_DONE))
      else $error("result word without a finished request");

endmodule

`default_nettype wire

@@ sim/tb_bitmap_page_frame_allocator.sv @@
// Self-checking testbench for the first-fit bitmap page frame allocator.
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator;
   import bpfa_pkg::*;

   localparam int MAX_FRAMES  = 32768;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = MAX_FRAMES / WORD_BITS;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [FRAME_W-1:0]  granted;
      logic [STATUS_W-1:0] status;
   } answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [REQ_W-1:0]      req_type = REQ_ALLOC;
   logic [FRAME_W-1:0]    req_frame = '0;
   logic [RUN_W-1:0]      req_run_length = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [FRAME_W-1:0]    rsp_granted_frame;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = ADDR_BLOCK_COUNT;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   logic [WORD_BITS-1:0]  frame_used [MAP_WORDS];
   logic [BC_W-1:0]       managed_frames;
   answer_type            awaited_answers [$];
   logic [FRAME_W-1:0]    handed_out [$];
   int                    mismatches = 0;
   int                    cycle_count = 0;
   bit                    sender_idle = 1'b1;
   bit                    receiver_idle = 1'b1;
   int                    hold_order = 0;
   int                    hold_left = 0;
   int                    rsp_pause = 0;

   bitmap_page_frame_allocator #(
      .MAX_FRAMES(MAX_FRAMES),
      .WORD_BITS (WORD_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_frame        (req_frame),
      .req_run_length   (req_run_length),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_granted_frame(rsp_granted_frame),
      .rsp_status       (rsp_status),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic answer_type apply_request(input logic [REQ_W-1:0] kind,
                                                input logic [FRAME_W-1:0] frm,
                                                input logic [RUN_W-1:0] run);
      answer_type ans;
      int      words;
      int      stop;
      int      i;
      int      j;
      bit      found;
      ans.granted = '0;
      ans.status  = STATUS_OK;
      case (kind)
         REQ_ALLOC: begin
            words = int'(managed_frames) / WORD_BITS;
            if (words > MAP_WORDS) words = MAP_WORDS;
            found = 1'b0;
            for (i = 0; i < words && !found; i++) begin
               if (frame_used[i] != '1) begin
                  for (j = 0; j < WORD_BITS && !found; j++) begin
                     if (!frame_used[i][j]) begin
                        frame_used[i][j] = 1'b1;
                        ans.granted = FRAME_W'(i * WORD_BITS + j);
                        found = 1'b1;
                     end
                  end
               end
            end
            if (!found) ans.status = STATUS_NOMEM;
         end
         REQ_FREE: begin
            if (int'(frm) < int'(managed_frames))
               frame_used[frm / WORD_BITS][frm % WORD_BITS] = 1'b0;
            else
               ans.status = STATUS_RANGE;
         end
         default: begin
            stop = int'(frm) + int'(run);
            if (stop > MAX_FRAMES) stop = MAX_FRAMES;
            for (i = frm; i < stop; i++)
               frame_used[i / WORD_BITS][i % WORD_BITS] = (kind == REQ_RESERVE);
         end
      endcase
      return ans;
   endfunction

   task automatic issue_request(input logic [REQ_W-1:0] kind,
                                input logic [FRAME_W-1:0] frm,
                                input logic [RUN_W-1:0] run);
      answer_type ans;
      int      gap;
      gap = sender_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_frame      <= frm;
      req_run_length <= run;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      ans = apply_request(kind, frm, run);
      awaited_answers.push_back(ans);
      if (kind == REQ_ALLOC && ans.status == STATUS_OK) handed_out.push_back(ans.granted);
   endtask

   task automatic wait_all_answered;
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_answers.size() != 0) @(posedge clock);
   endtask

   task automatic csr_transfer(input bit write_op, input logic [BC_W-1:0] value,
                               output logic [31:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write_op;
      paddr   <= ADDR_BLOCK_COUNT;
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_block_count;
      logic [31:0] rdata;
      csr_transfer(1'b0, '0, rdata);
      if (rdata[BC_W-1:0] !== managed_frames) begin
         $display("%0t: block_count read expected %0d actual %0d",
                  $time, managed_frames, rdata[BC_W-1:0]);
         mismatches++;
      end
   endtask

   task automatic set_block_count(input logic [BC_W-1:0] value);
      logic [31:0] rdata;
      csr_transfer(1'b1, value, rdata);
      managed_frames = value;
      check_block_count;
   endtask

   task automatic random_request(input int span);
      int                 pick;
      int                 idx;
      logic [REQ_W-1:0]   kind;
      logic [FRAME_W-1:0] frm;
      logic [RUN_W-1:0]   run;
      pick = $urandom_range(0, 99);
      frm  = ($urandom_range(0, 4) == 0) ? FRAME_W'($urandom_range(0, MAX_FRAMES - 1))
                                         : FRAME_W'($urandom_range(0, span + 63));
      run  = ($urandom_range(0, 9) == 0) ? RUN_W'($urandom_range(0, 1024))
                                         : RUN_W'($urandom_range(0, 80));
      if (pick < 40) begin
         kind = REQ_ALLOC;
      end else if (pick < 65) begin
         kind = REQ_FREE;
         if (handed_out.size() > 0 && $urandom_range(0, 1) == 1) begin
            idx = $urandom_range(0, handed_out.size() - 1);
            frm = handed_out[idx];
            handed_out.delete(idx);
         end
      end else begin
         kind = (pick < 80) ? REQ_RESERVE : REQ_RELEASE;
         if ($urandom_range(0, 19) == 0) begin
            frm = FRAME_W'($urandom_range(MAX_FRAMES - 256, MAX_FRAMES - 1));
            run = RUN_W'($urandom_range(0, 65535));
         end
      end
      issue_request(kind, frm, run);
   endtask

   task automatic test_register_reset;
      check_block_count;
   endtask

   task automatic test_exhausted_map;
      issue_request(REQ_ALLOC, 15'd0, 16'd0);
   endtask

   task automatic test_free_extremes;
      issue_request(REQ_FREE, 15'd0, 16'd0);
      issue_request(REQ_ALLOC, 15'd0, 16'd0);
      issue_request(REQ_FREE, 15'h7fff, 16'hffff);
      issue_request(REQ_ALLOC, 15'h7fff, 16'hffff);
   endtask

   task automatic test_range_clipping;
      issue_request(REQ_RELEASE, 15'd0, 16'd0);
      issue_request(REQ_RELEASE, 15'd32760, 16'hffff);
      issue_request(REQ_RESERVE, 15'd32760, 16'h8000);
   endtask

   task automatic test_whole_store;
      issue_request(REQ_RELEASE, 15'd0, 16'h8000);
      issue_request(REQ_ALLOC, 15'd0, 16'd0);
      issue_request(REQ_ALLOC, 15'd0, 16'd0);
      issue_request(REQ_RESERVE, 15'd0, 16'h8000);
   endtask

   task automatic test_zero_block_count;
      wait_all_answered;
      set_block_count(16'd0);
      issue_request(REQ_ALLOC, 15'd0, 16'd0);
      issue_request(REQ_FREE, 15'd0, 16'd0);
   endtask

   task automatic test_partial_last_word;
      wait_all_answered;
      set_block_count(16'd40);
      issue_request(REQ_RELEASE, 15'd0, 16'd64);
      issue_request(REQ_RESERVE, 15'd0, 16'd32);
      issue_request(REQ_ALLOC, 15'd0, 16'd0);
      issue_request(REQ_FREE, 15'd39, 16'd0);
      issue_request(REQ_FREE, 15'd40, 16'd0);
      issue_request(REQ_FREE, 15'd63, 16'd0);
   endtask

   task automatic test_random_mix(input int count, input logic [BC_W-1:0] limit,
                                  input int span, input bit idle, input bit pause_midway);
      int n;
      wait_all_answered;
      set_block_count(limit);
      sender_idle   = idle;
      receiver_idle = idle;
      issue_request(REQ_RELEASE, 15'd0, RUN_W'(span));
      for (n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) wait_all_answered;
         random_request(span);
      end
   endtask

   // The receiver stops taking results for a long stretch while requests keep coming.
   task automatic test_backpressure(input int count, input int span);
      int n;
      hold_order  = 300;
      sender_idle = 1'b0;
      for (n = 0; n < count; n++) random_request(span);
      sender_idle = 1'b1;
   endtask

   always @(posedge clock) begin : answer_check
      answer_type head;
      if (rsp_valid === 1'b1 && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: unexpected word, expected none actual granted_frame %0d status %0d",
                     $time, rsp_granted_frame, rsp_status);
            mismatches++;
         end else begin
            head = awaited_answers.pop_front();
            if (rsp_granted_frame !== head.granted) begin
               $display("%0t: granted_frame expected %0d actual %0d",
                        $time, head.granted, rsp_granted_frame);
               mismatches++;
            end
            if (rsp_status !== head.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, head.status, rsp_status);
               mismatches++;
            end
         end
         rsp_pause = receiver_idle ? $urandom_range(0, 5) : 0;
      end else if (rsp_pause > 0) begin
         rsp_pause--;
      end
      if (hold_order > 0) begin
         hold_left  = hold_order;
         hold_order = 0;
      end else if (hold_left > 0) begin
         hold_left--;
      end
      rsp_ready <= (rsp_pause == 0 && hold_left == 0);
   end

   initial begin : run_tests
      int span;
      for (int i = 0; i < MAP_WORDS; i++) frame_used[i] = '1;
      managed_frames = BLOCK_COUNT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_register_reset;
      test_exhausted_map;
      test_free_extremes;
      test_range_clipping;
      test_whole_store;
      test_zero_block_count;
      test_partial_last_word;

      test_random_mix(100, 16'd256, 256, 1'b1, 1'b0);
      test_backpressure(20, 256);
      span = $urandom_range(33, 1000);
      test_random_mix(100, BC_W'(span), span, 1'b0, 1'b1);
      test_random_mix(90, 16'd32768, 128, 1'b1, 1'b0);
      test_random_mix(90, BC_W'($urandom_range(0, 2047)), 512, 1'b1, 1'b1);

      wait_all_answered;
      repeat (64) @(posedge clock);
      if (mismatches == 0 && awaited_answers.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
